// ----- design/pcdp_pkg.sv -----
package pcdp_pkg;

    localparam int TOTAL_W = 7;
    localparam int PARTS_W = 7;
    localparam int COUNT_W = 21;
    localparam int STEP_W  = 4;

    typedef logic [STEP_W-1:0] step_t;

    // Microprogram addresses
    localparam step_t S_IDLE   = 4'd0;
    localparam step_t S_CHECK  = 4'd1;
    localparam step_t S_CLR    = 4'd2;
    localparam step_t S_JSTART = 4'd3;
    localparam step_t S_IINIT  = 4'd4;
    localparam step_t S_UPD    = 4'd5;
    localparam step_t S_JNEXT  = 4'd6;
    localparam step_t S_ANS    = 4'd7;
    localparam step_t S_RES    = 4'd8;
    localparam step_t S_ERR    = 4'd9;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_IN_VALID,
        C_M_BIG,
        C_IDX_EQ_M,
        C_TOP_ZERO,
        C_J_EQ_TOP,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic  take_in;
        logic  idx_zero;
        logic  idx_j;
        logic  idx_inc;
        logic  clr_wr;
        logic  rd_upd;
        logic  rd_ans;
        logic  j_one;
        logic  j_inc;
        logic  res_ld;
        logic  res_err;
        cond_t cond;
        step_t tgt;
        step_t alt;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic m_big;
        logic idx_eq_m;
        logic top_zero;
        logic j_eq_top;
        logic out_free;
    } dstat_t;

    // Control store: one word per step, jump to tgt when cond holds, else alt
    function automatic uword_t ucode(step_t s);
        uword_t w;
        w      = '0;
        w.cond = C_ALWAYS;
        w.tgt  = S_IDLE;
        w.alt  = S_IDLE;
        case (s)
            S_IDLE:
            begin
                w.take_in = 1'b1;
                w.cond    = C_IN_VALID;
                w.tgt     = S_CHECK;
                w.alt     = S_IDLE;
            end
            S_CHECK:
            begin
                w.idx_zero = 1'b1;
                w.cond     = C_M_BIG;
                w.tgt      = S_ERR;
                w.alt      = S_CLR;
            end
            S_CLR:
            begin
                w.clr_wr  = 1'b1;
                w.idx_inc = 1'b1;
                w.cond    = C_IDX_EQ_M;
                w.tgt     = S_JSTART;
                w.alt     = S_CLR;
            end
            S_JSTART:
            begin
                w.j_one = 1'b1;
                w.cond  = C_TOP_ZERO;
                w.tgt   = S_ANS;
                w.alt   = S_IINIT;
            end
            S_IINIT:
            begin
                w.idx_j = 1'b1;
                w.cond  = C_ALWAYS;
                w.tgt   = S_UPD;
                w.alt   = S_UPD;
            end
            S_UPD:
            begin
                w.rd_upd  = 1'b1;
                w.idx_inc = 1'b1;
                w.cond    = C_IDX_EQ_M;
                w.tgt     = S_JNEXT;
                w.alt     = S_UPD;
            end
            S_JNEXT:
            begin
                w.j_inc = 1'b1;
                w.cond  = C_J_EQ_TOP;
                w.tgt   = S_ANS;
                w.alt   = S_IINIT;
            end
            S_ANS:
            begin
                w.rd_ans = 1'b1;
                w.cond   = C_ALWAYS;
                w.tgt    = S_RES;
                w.alt    = S_RES;
            end
            S_RES:
            begin
                w.res_ld = 1'b1;
                w.cond   = C_OUT_FREE;
                w.tgt    = S_IDLE;
                w.alt    = S_RES;
            end
            S_ERR:
            begin
                w.res_ld  = 1'b1;
                w.res_err = 1'b1;
                w.cond    = C_OUT_FREE;
                w.tgt     = S_IDLE;
                w.alt     = S_ERR;
            end
            default:
            begin
                w.tgt = S_IDLE;
                w.alt = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- design/pcdp_seq.sv -----
module pcdp_seq
    import pcdp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  dstat_t stat,
    output uword_t ctrl
);

    step_t step_reg;
    step_t step_next;
    logic  cond_hit;

    always_comb
    begin
        ctrl = ucode(step_reg);
    end

    always_comb
    begin
        case (ctrl.cond)
            C_ALWAYS:   cond_hit = 1'b1;
            C_IN_VALID: cond_hit = stat.in_valid;
            C_M_BIG:    cond_hit = stat.m_big;
            C_IDX_EQ_M: cond_hit = stat.idx_eq_m;
            C_TOP_ZERO: cond_hit = stat.top_zero;
            C_J_EQ_TOP: cond_hit = stat.j_eq_top;
            C_OUT_FREE: cond_hit = stat.out_free;
            default:    cond_hit = 1'b1;
        endcase
        step_next = cond_hit ? ctrl.tgt : ctrl.alt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- design/pcdp_dp.sv -----
module pcdp_dp
    import pcdp_pkg::*;
#(
    parameter int MAX_TOTAL = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  uword_t             ctrl,
    input  logic               in_valid,
    input  logic [TOTAL_W-1:0] total,
    input  logic [PARTS_W-1:0] parts,
    input  logic               out_stall,
    output dstat_t             stat,
    output logic               out_valid,
    output logic [COUNT_W-1:0] count
);

    localparam int ADDR_W = $clog2(MAX_TOTAL + 1);

    logic [COUNT_W-1:0] ways_mem [MAX_TOTAL+1];

    logic [TOTAL_W-1:0] m_reg;
    logic [PARTS_W-1:0] n_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic [ADDR_W-1:0]  idx_next;
    logic [ADDR_W-1:0]  j_reg;
    logic [ADDR_W-1:0]  j_next;
    logic [ADDR_W-1:0]  wr_addr_reg;
    logic               pend_reg;
    logic               fwd_reg;
    logic [COUNT_W-1:0] fwd_val_reg;
    logic [COUNT_W-1:0] rd_a_reg;
    logic [COUNT_W-1:0] rd_b_reg;
    logic               out_valid_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [ADDR_W-1:0]  m_addr;
    logic [ADDR_W-1:0]  top;
    logic [ADDR_W-1:0]  rd_a_addr;
    logic [ADDR_W-1:0]  rd_b_addr;
    logic [COUNT_W-1:0] upd_sum;
    logic [COUNT_W-1:0] clr_data;
    logic               take;
    logic               out_free;

    assign m_addr    = m_reg[ADDR_W-1:0];
    assign top       = (n_reg < m_reg) ? n_reg[ADDR_W-1:0] : m_addr;
    assign rd_a_addr = ctrl.rd_ans ? m_addr : idx_reg;
    assign rd_b_addr = idx_reg - j_reg;
    // a part size of one reads the entry written in this same cycle
    assign upd_sum   = rd_a_reg + (fwd_reg ? fwd_val_reg : rd_b_reg);
    assign clr_data  = {{(COUNT_W-1){1'b0}}, (idx_reg == '0)};
    assign take      = ctrl.take_in && in_valid;
    assign out_free  = !out_valid_reg || !out_stall;

    assign stat.in_valid = in_valid;
    assign stat.m_big    = (m_reg > TOTAL_W'(MAX_TOTAL));
    assign stat.idx_eq_m = (idx_reg == m_addr);
    assign stat.top_zero = (top == '0);
    assign stat.j_eq_top = (j_reg == top);
    assign stat.out_free = out_free;

    always_comb
    begin
        idx_next = idx_reg;
        if (ctrl.idx_zero)
        begin
            idx_next = '0;
        end
        else if (ctrl.idx_j)
        begin
            idx_next = j_reg;
        end
        else if (ctrl.idx_inc)
        begin
            idx_next = idx_reg + ADDR_W'(1);
        end
        j_next = j_reg;
        if (ctrl.j_one)
        begin
            j_next = ADDR_W'(1);
        end
        else if (ctrl.j_inc)
        begin
            j_next = j_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            ways_mem[wr_addr_reg] <= upd_sum;
        end
        else if (ctrl.clr_wr)
        begin
            ways_mem[idx_reg] <= clr_data;
        end
        if (ctrl.rd_upd || ctrl.rd_ans)
        begin
            rd_a_reg <= ways_mem[rd_a_addr];
            rd_b_reg <= ways_mem[rd_b_addr];
        end
        if (take)
        begin
            m_reg <= total;
            n_reg <= parts;
        end
        idx_reg     <= idx_next;
        j_reg       <= j_next;
        wr_addr_reg <= idx_reg;
        fwd_val_reg <= upd_sum;
        if (ctrl.res_ld && out_free)
        begin
            count_reg <= ctrl.res_err ? '0 : rd_a_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= ctrl.rd_upd;
            fwd_reg  <= ctrl.rd_upd && pend_reg && (rd_b_addr == wr_addr_reg);
            if (ctrl.res_ld && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign count     = count_reg;

endmodule

// ----- design/partition_count_dp_core.sv -----
// Partition counter: for each query (total, parts) returns the number of ways
// to split total into at most parts unordered non-negative parts.
// Input channel: in_valid / in_stall with fields total and parts. A query
// transfers when in_valid is high and in_stall is low; in_stall is high
// while a query is in work, so one query is handled at a time.
// Output channel: out_valid / out_stall with field count, held in an output
// register. While the receiver stalls, count and out_valid hold, and a new
// query can already transfer in.
// Work for a query, with m = total and t = min(parts, total): entries
// 0..m of the work memory are cleared, then for each j = 1..t entries
// j..m are updated, then entry m is read out as the count. The single
// work memory, one read-add-write per cycle, carries each update.
// A total above MAX_TOTAL returns count 0 without building the table.
// Control is a ten-step microprogram; a step counter walks it with
// conditional jumps. Reset returns the sequencer to the idle step and
// drops any pending result; the work memory is rebuilt by every query
// whose total is within MAX_TOTAL.
module partition_count_dp_core
    import pcdp_pkg::*;
#(
    parameter int MAX_TOTAL = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [TOTAL_W-1:0] total,
    input  logic [PARTS_W-1:0] parts,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [COUNT_W-1:0] count
);

    uword_t ctrl;
    dstat_t stat;

    pcdp_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    pcdp_dp #(
        .MAX_TOTAL (MAX_TOTAL)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .in_valid  (in_valid),
        .total     (total),
        .parts     (parts),
        .out_stall (out_stall),
        .stat      (stat),
        .out_valid (out_valid),
        .count     (count)
    );

    assign in_stall = !ctrl.take_in;

endmodule

// ----- design/pcdp_chk.sv -----
module pcdp_chk
    import pcdp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [TOTAL_W-1:0] total,
    input logic [PARTS_W-1:0] parts,
    input logic               out_valid,
    input logic               out_stall,
    input logic [COUNT_W-1:0] count
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(count))
        else $error("stalled result changed");

    // a transferred query keeps the input closed for the next cycle
    a_busy_1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input reopened one cycle after transfer");

    a_busy_2: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> ##1 in_stall)
        else $error("input reopened two cycles after transfer");

    // a new result only comes out of a query in work
    a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a query in work");

endmodule

bind partition_count_dp_core pcdp_chk u_chk (.*);
